// ===== rtl/rfub_pkg.sv =====
// shared types and constants for the rotate / flip / upscale blitter
`timescale 1ns / 1ps

package rfub_pkg;

  localparam int PHYS_BITS     = 15;
  localparam int COLOR_BITS    = 32;
  localparam int CFG_MAG_BITS  = 4;
  localparam int CFG_ROT_BITS  = 2;
  localparam int CFG_SIZE_BITS = 13;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 13;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_MAGNIFICATION  = 2'd0,
    REG_ROTATION       = 2'd1,
    REG_LOGICAL_WIDTH  = 2'd2,
    REG_LOGICAL_HEIGHT = 2'd3
  } reg_index_t;

  typedef enum logic [CFG_ROT_BITS-1:0] {
    ROT_NONE        = 2'd0,
    ROT_RIGHT       = 2'd1,
    ROT_UPSIDE_DOWN = 2'd2,
    ROT_LEFT        = 2'd3
  } rotation_t;

  // one scaled source pixel, ready for replication
  typedef struct packed {
    logic [PHYS_BITS-1:0]  px;
    logic [PHYS_BITS-1:0]  py;
    logic [PHYS_BITS-1:0]  dl;
    logic [PHYS_BITS-1:0]  dt;
    logic [PHYS_BITS-1:0]  dr;
    logic [PHYS_BITS-1:0]  db;
    logic [COLOR_BITS-1:0] color;
    logic                  end_rect;
    logic                  bad;
  } scaled_t;

endpackage

// ===== rtl/rfub_xform.sv =====
// input register, rectangle walk and rotation / flip of logical coordinates
`timescale 1ns / 1ps

module rfub_xform #(
  parameter int CB = 12
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [rfub_pkg::CFG_ROT_BITS-1:0]   rotation,
  input  logic [CB:0]                         w_eff,
  input  logic [CB:0]                         h_eff,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [CB-1:0]                       rect_left,
  input  logic [CB-1:0]                       rect_top,
  input  logic [CB-1:0]                       rect_right,
  input  logic [CB-1:0]                       rect_bottom,
  input  logic [rfub_pkg::COLOR_BITS-1:0]     pixel_color,
  output logic                                x_valid,
  input  logic                                x_ready,
  output logic [CB-1:0]                       x_tx,
  output logic [CB-1:0]                       x_ty,
  output logic [CB-1:0]                       x_x0,
  output logic [CB-1:0]                       x_y0,
  output logic [CB-1:0]                       x_x1,
  output logic [CB-1:0]                       x_y1,
  output logic [rfub_pkg::COLOR_BITS-1:0]     x_color,
  output logic                                x_end_rect,
  output logic                                x_bad
);
  import rfub_pkg::*;

  localparam int SZ_W = CB + 1;

  logic                  iv;
  logic [CB-1:0]         il, it, ir, ib;
  logic [COLOR_BITS-1:0] ic;
  logic [CB-1:0]         src_col, src_row;
  logic [CB-1:0]         src_col_next, src_row_next;

  logic          x_free, take;
  logic          bad, restart, swap_xy, flip_v, flip_h, end_rect;
  logic [SZ_W-1:0] rw, rh, c1, r1;
  logic [CB-1:0] c, r, tx0, ty0, tx1, ty1, tx, ty;
  logic [CB-1:0] ya, yb, xa, xb, x0, y0, x1, y1;

  assign x_free   = !x_valid || x_ready;
  assign take     = iv && x_free;
  assign in_stall = iv && !x_free;

  always_comb begin
    swap_xy = (rotation == ROT_RIGHT) || (rotation == ROT_LEFT);
    flip_v  = (rotation == ROT_RIGHT) || (rotation == ROT_UPSIDE_DOWN);
    flip_h  = (rotation == ROT_UPSIDE_DOWN) || (rotation == ROT_LEFT);

    bad = (il > ir) || (it > ib) || (SZ_W'(ir) >= w_eff) || (SZ_W'(ib) >= h_eff);
    rw  = SZ_W'(ir) - SZ_W'(il) + SZ_W'(1);
    rh  = SZ_W'(ib) - SZ_W'(it) + SZ_W'(1);
    restart = (SZ_W'(src_col) >= rw) || (SZ_W'(src_row) >= rh);
    c   = restart ? '0 : src_col;
    r   = restart ? '0 : src_row;
    c1  = SZ_W'(c) + SZ_W'(1);
    r1  = SZ_W'(r) + SZ_W'(1);
    end_rect = (c1 == rw) && (r1 == rh);

    // pixel position
    tx0 = il + c;
    ty0 = it + r;
    ty1 = flip_v ? CB'(h_eff - SZ_W'(1) - SZ_W'(ty0)) : ty0;
    tx1 = flip_h ? CB'(w_eff - SZ_W'(1) - SZ_W'(tx0)) : tx0;
    tx  = swap_xy ? ty1 : tx1;
    ty  = swap_xy ? tx1 : ty1;

    // rectangle corners
    ya = flip_v ? CB'(h_eff - SZ_W'(1) - SZ_W'(ib)) : it;
    yb = flip_v ? CB'(h_eff - SZ_W'(1) - SZ_W'(it)) : ib;
    xa = flip_h ? CB'(w_eff - SZ_W'(1) - SZ_W'(ir)) : il;
    xb = flip_h ? CB'(w_eff - SZ_W'(1) - SZ_W'(il)) : ir;
    x0 = swap_xy ? ya : xa;
    y0 = swap_xy ? xa : ya;
    x1 = swap_xy ? yb : xb;
    y1 = swap_xy ? xb : yb;

    // walk to the next source pixel
    if (bad) begin
      src_col_next = '0;
      src_row_next = '0;
    end else if (c1 >= rw) begin
      src_col_next = '0;
      src_row_next = (r1 >= rh) ? '0 : CB'(r1);
    end else begin
      src_col_next = CB'(c1);
      src_row_next = r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      iv      <= 1'b0;
      x_valid <= 1'b0;
      src_col <= '0;
      src_row <= '0;
    end else begin
      if (!iv || x_free) begin
        iv <= in_valid;
      end
      if (x_free) begin
        x_valid <= iv;
      end
      if (take) begin
        src_col <= src_col_next;
        src_row <= src_row_next;
      end
    end
    if (!iv || x_free) begin
      il <= rect_left;
      it <= rect_top;
      ir <= rect_right;
      ib <= rect_bottom;
      ic <= pixel_color;
    end
    if (x_free) begin
      x_tx       <= tx;
      x_ty       <= ty;
      x_x0       <= x0;
      x_y0       <= y0;
      x_x1       <= x1;
      x_y1       <= y1;
      x_color    <= ic;
      x_end_rect <= end_rect;
      x_bad      <= bad;
    end
  end

endmodule

// ===== rtl/rfub_scale.sv =====
// multiply logical coordinates by the magnification into physical space
`timescale 1ns / 1ps

module rfub_scale #(
  parameter int CB    = 12,
  parameter int MAG_W = 4
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [MAG_W-1:0]                mag,
  input  logic                            x_valid,
  output logic                            x_ready,
  input  logic [CB-1:0]                   x_tx,
  input  logic [CB-1:0]                   x_ty,
  input  logic [CB-1:0]                   x_x0,
  input  logic [CB-1:0]                   x_y0,
  input  logic [CB-1:0]                   x_x1,
  input  logic [CB-1:0]                   x_y1,
  input  logic [rfub_pkg::COLOR_BITS-1:0] x_color,
  input  logic                            x_end_rect,
  input  logic                            x_bad,
  output logic                            s_valid,
  input  logic                            s_ready,
  output rfub_pkg::scaled_t               s_word
);
  import rfub_pkg::*;

  localparam int PW = CB + 1 + MAG_W;

  logic [PW-1:0] m, ptx, pty, pl, pt, pr, pb;
  scaled_t       s_next;

  assign x_ready = !s_valid || s_ready;

  always_comb begin
    m   = PW'(mag);
    ptx = PW'(x_tx) * m;
    pty = PW'(x_ty) * m;
    pl  = PW'(x_x0) * m;
    pt  = PW'(x_y0) * m;
    pr  = (PW'(x_x1) + PW'(1)) * m - PW'(1);
    pb  = (PW'(x_y1) + PW'(1)) * m - PW'(1);
    if (x_bad) begin
      s_next     = '0;
      s_next.bad = 1'b1;
    end else begin
      s_next.px       = PHYS_BITS'(ptx);
      s_next.py       = PHYS_BITS'(pty);
      s_next.dl       = PHYS_BITS'(pl);
      s_next.dt       = PHYS_BITS'(pt);
      s_next.dr       = PHYS_BITS'(pr);
      s_next.db       = PHYS_BITS'(pb);
      s_next.color    = x_color;
      s_next.end_rect = x_end_rect;
      s_next.bad      = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (x_ready) begin
      s_valid <= x_valid;
    end
    if (x_ready) begin
      s_word <= s_next;
    end
  end

endmodule

// ===== rtl/rfub_repl.sv =====
// replica sequencer: magnification squared writes per pixel (one for a bad rectangle) into the output register
`timescale 1ns / 1ps

module rfub_repl #(
  parameter int MAG_W = 4,
  parameter int CNT_W = 3
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [MAG_W-1:0]                    mag,
  input  logic                                s_valid,
  output logic                                s_ready,
  input  rfub_pkg::scaled_t                   s_word,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [rfub_pkg::PHYS_BITS-1:0]      dest_x,
  output logic [rfub_pkg::PHYS_BITS-1:0]      dest_y,
  output logic [rfub_pkg::COLOR_BITS-1:0]     write_color,
  output logic [rfub_pkg::PHYS_BITS-1:0]      dest_left,
  output logic [rfub_pkg::PHYS_BITS-1:0]      dest_top,
  output logic [rfub_pkg::PHYS_BITS-1:0]      dest_right,
  output logic [rfub_pkg::PHYS_BITS-1:0]      dest_bottom,
  output logic                                last_of_pixel,
  output logic                                last_of_rect,
  output logic                                bad_rect
);
  import rfub_pkg::*;

  logic       cur_valid;
  scaled_t    cur;
  logic [CNT_W-1:0] mx, my;

  logic       o_free, emit, col_last, row_last, last, done;

  assign o_free   = !out_valid || !out_stall;
  assign emit     = cur_valid && o_free;
  assign col_last = (MAG_W'(mx) == mag - MAG_W'(1));
  assign row_last = (MAG_W'(my) == mag - MAG_W'(1));
  assign last     = col_last && row_last;
  assign done     = emit && (cur.bad || last);
  assign s_ready  = !cur_valid || done;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      out_valid <= 1'b0;
      mx        <= '0;
      my        <= '0;
    end else begin
      if (s_ready) begin
        cur_valid <= s_valid;
        mx        <= '0;
        my        <= '0;
      end else if (emit) begin
        if (col_last) begin
          mx <= '0;
          my <= my + CNT_W'(1);
        end else begin
          mx <= mx + CNT_W'(1);
        end
      end
      if (o_free) begin
        out_valid <= emit;
      end
    end
    if (s_ready) begin
      cur <= s_word;
    end
    if (o_free) begin
      dest_x        <= cur.px + PHYS_BITS'(mx);
      dest_y        <= cur.py + PHYS_BITS'(my);
      write_color   <= cur.color;
      dest_left     <= cur.dl;
      dest_top      <= cur.dt;
      dest_right    <= cur.dr;
      dest_bottom   <= cur.db;
      last_of_pixel <= !cur.bad && last;
      last_of_rect  <= !cur.bad && last && cur.end_rect;
      bad_rect      <= cur.bad;
    end
  end

endmodule

// ===== rtl/rotate_flip_upscale_blit.sv =====
// top level of the rotate / flip / upscale blitter
`timescale 1ns / 1ps

// Each accepted source pixel produces magnification squared physical writes (one for a bad
// rectangle), one per cycle on the output port while out_stall is low; the replica
// sequencer issues a single write per cycle. Input words are taken while earlier pixels are
// still being replicated, through an input register, a transform stage and a scale
// stage in front of the replica sequencer.

module rotate_flip_upscale_blit #(
  parameter int MAX_MAG    = 8,
  parameter int COORD_BITS = 12
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [rfub_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [rfub_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [COORD_BITS-1:0]                rect_left,
  input  logic [COORD_BITS-1:0]                rect_top,
  input  logic [COORD_BITS-1:0]                rect_right,
  input  logic [COORD_BITS-1:0]                rect_bottom,
  input  logic [rfub_pkg::COLOR_BITS-1:0]      pixel_color,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [rfub_pkg::PHYS_BITS-1:0]       dest_x,
  output logic [rfub_pkg::PHYS_BITS-1:0]       dest_y,
  output logic [rfub_pkg::COLOR_BITS-1:0]      write_color,
  output logic [rfub_pkg::PHYS_BITS-1:0]       dest_left,
  output logic [rfub_pkg::PHYS_BITS-1:0]       dest_top,
  output logic [rfub_pkg::PHYS_BITS-1:0]       dest_right,
  output logic [rfub_pkg::PHYS_BITS-1:0]       dest_bottom,
  output logic                                 last_of_pixel,
  output logic                                 last_of_rect,
  output logic                                 bad_rect
);
  import rfub_pkg::*;

  localparam int MAG_W = $clog2(MAX_MAG + 1);
  localparam int CNT_W = (MAX_MAG > 1) ? $clog2(MAX_MAG) : 1;
  localparam int SZ_W  = COORD_BITS + 1;
  localparam int CMP_W = (SZ_W > CFG_SIZE_BITS) ? SZ_W : CFG_SIZE_BITS;

  logic [CFG_MAG_BITS-1:0]  magnification;
  logic [CFG_ROT_BITS-1:0]  rotation;
  logic [CFG_SIZE_BITS-1:0] logical_width;
  logic [CFG_SIZE_BITS-1:0] logical_height;

  logic [MAG_W-1:0] mag_eff;
  logic [CMP_W-1:0] lw_ext, lh_ext, size_lim;
  logic [SZ_W-1:0]  w_eff, h_eff;

  logic                  x_valid, x_ready, x_end_rect, x_bad;
  logic [COORD_BITS-1:0] x_tx, x_ty, x_x0, x_y0, x_x1, x_y1;
  logic [COLOR_BITS-1:0] x_color;
  logic                  s_valid, s_ready;
  scaled_t               s_word;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      magnification  <= CFG_MAG_BITS'(1);
      rotation       <= ROT_NONE;
      logical_width  <= CFG_SIZE_BITS'(320);
      logical_height <= CFG_SIZE_BITS'(240);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MAGNIFICATION:  magnification  <= cfg_data[CFG_MAG_BITS-1:0];
        REG_ROTATION:       rotation       <= cfg_data[CFG_ROT_BITS-1:0];
        REG_LOGICAL_WIDTH:  logical_width  <= cfg_data[CFG_SIZE_BITS-1:0];
        REG_LOGICAL_HEIGHT: logical_height <= cfg_data[CFG_SIZE_BITS-1:0];
        default: ;
      endcase
    end
  end

  // saturate magnification and logical size
  always_comb begin
    if (magnification == '0) begin
      mag_eff = MAG_W'(1);
    end else if (magnification > CFG_MAG_BITS'(MAX_MAG)) begin
      mag_eff = MAG_W'(MAX_MAG);
    end else begin
      mag_eff = MAG_W'(magnification);
    end
    lw_ext   = CMP_W'(logical_width);
    lh_ext   = CMP_W'(logical_height);
    size_lim = CMP_W'(1) << COORD_BITS;
    w_eff    = SZ_W'((lw_ext > size_lim) ? size_lim : lw_ext);
    h_eff    = SZ_W'((lh_ext > size_lim) ? size_lim : lh_ext);
  end

  rfub_xform #(
    .CB (COORD_BITS)
  ) u_xform (
    .clk         (clk),
    .rst         (rst),
    .rotation    (rotation),
    .w_eff       (w_eff),
    .h_eff       (h_eff),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .rect_left   (rect_left),
    .rect_top    (rect_top),
    .rect_right  (rect_right),
    .rect_bottom (rect_bottom),
    .pixel_color (pixel_color),
    .x_valid     (x_valid),
    .x_ready     (x_ready),
    .x_tx        (x_tx),
    .x_ty        (x_ty),
    .x_x0        (x_x0),
    .x_y0        (x_y0),
    .x_x1        (x_x1),
    .x_y1        (x_y1),
    .x_color     (x_color),
    .x_end_rect  (x_end_rect),
    .x_bad       (x_bad)
  );

  rfub_scale #(
    .CB    (COORD_BITS),
    .MAG_W (MAG_W)
  ) u_scale (
    .clk        (clk),
    .rst        (rst),
    .mag        (mag_eff),
    .x_valid    (x_valid),
    .x_ready    (x_ready),
    .x_tx       (x_tx),
    .x_ty       (x_ty),
    .x_x0       (x_x0),
    .x_y0       (x_y0),
    .x_x1       (x_x1),
    .x_y1       (x_y1),
    .x_color    (x_color),
    .x_end_rect (x_end_rect),
    .x_bad      (x_bad),
    .s_valid    (s_valid),
    .s_ready    (s_ready),
    .s_word     (s_word)
  );

  rfub_repl #(
    .MAG_W (MAG_W),
    .CNT_W (CNT_W)
  ) u_repl (
    .clk           (clk),
    .rst           (rst),
    .mag           (mag_eff),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .s_word        (s_word),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .dest_x        (dest_x),
    .dest_y        (dest_y),
    .write_color   (write_color),
    .dest_left     (dest_left),
    .dest_top      (dest_top),
    .dest_right    (dest_right),
    .dest_bottom   (dest_bottom),
    .last_of_pixel (last_of_pixel),
    .last_of_rect  (last_of_rect),
    .bad_rect      (bad_rect)
  );

  // a bad rectangle word carries nothing but its flag
  a_bad_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && bad_rect |-> !last_of_pixel && !last_of_rect && dest_x == '0 &&
      dest_y == '0 && write_color == '0 && dest_right == '0)
    else $error("bad rectangle word carries data");

  a_rect_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && last_of_rect |-> last_of_pixel)
    else $error("end of rectangle without end of pixel");

  a_unit_scale: assert property (@(posedge clk) disable iff (rst)
    out_valid && !bad_rect && mag_eff == MAG_W'(1) |-> last_of_pixel)
    else $error("unit scale word not marked last of pixel");

  a_reset_quiet: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !out_valid)
    else $error("output valid right after reset");

endmodule
